// ===== sv/two_pool_page_free_list_allocator_unit_assert.svh =====
// Assertion macros shared by the page free list allocator modules.
// Each macro is a concurrent assertion on clk_i, off in reset, or else empty.
// Needs clk_i and rst_ni in the scope of the module that uses it.
`ifndef TWO_POOL_PAGE_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_POOL_PAGE_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PFL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pfl assertion failed");
`define PFL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfl implication failed");
`else
`define PFL_ASSERT(name, prop)
`define PFL_ASSERT_IMP(name, ante, cons)
`endif
`endif

// ===== sv/pfl_pkg.sv =====
// Package of the page free list allocator: sizes, codes and shared types.
// Used by every module of the block but pfl_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pfl_pkg;

  localparam int ADDR_W      = 40;
  localparam int SMALL_PAGES = 32768;
  localparam int SUPER_PAGES = 64;
  localparam int SMALL_SHIFT = 12;
  localparam int SUPER_SHIFT = 21;

  localparam int SMALL_PN_W  = ADDR_W - SMALL_SHIFT;
  localparam int SUPER_PN_W  = ADDR_W - SUPER_SHIFT;
  localparam int SMALL_AW    = (SMALL_PAGES > 1) ? $clog2(SMALL_PAGES) : 1;
  localparam int SUPER_AW    = (SUPER_PAGES > 1) ? $clog2(SUPER_PAGES) : 1;
  localparam int SMALL_TOP_W = $clog2(SMALL_PAGES + 1);
  localparam int SUPER_TOP_W = $clog2(SUPER_PAGES + 1);

  localparam int APB_AW = 5;
  localparam int APB_DW = 64;

  typedef enum logic [2:0] {
    MODE_ALLOC_SMALL = 3'd0,
    MODE_FREE_SMALL  = 3'd1,
    MODE_ALLOC_SUPER = 3'd2,
    MODE_FREE_SUPER  = 3'd3,
    MODE_INIT        = 3'd4
  } pfl_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } pfl_status_e;

  typedef enum logic [1:0] {
    REG_SMALL_START = 2'd0,
    REG_SUPER_BASE  = 2'd1,
    REG_PHYS_TOP    = 2'd2
  } pfl_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_INIT
  } pfl_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] small_start;
    logic [ADDR_W-1:0] super_base;
    logic [ADDR_W-1:0] phys_top;
  } pfl_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    pfl_status_e       status;
  } pfl_result_t;

  typedef struct packed {
    logic                  we;
    logic [SMALL_AW-1:0]   addr;
    logic [SMALL_PN_W-1:0] wdata;
  } pfl_small_req_t;

  typedef struct packed {
    logic                  we;
    logic [SUPER_AW-1:0]   addr;
    logic [SUPER_PN_W-1:0] wdata;
  } pfl_super_req_t;

endpackage

`default_nettype wire

// ===== sv/pfl_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Standalone; used for both page stacks of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module pfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

// ===== sv/pfl_cfg_regs.sv =====
// APB-style configuration registers of the page free list allocator.
// Depends on pfl_pkg for widths and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module pfl_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pfl_pkg::APB_AW-1:0]  paddr,
  input  wire logic [pfl_pkg::APB_DW-1:0]  pwdata,
  output logic      [pfl_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output pfl_pkg::pfl_cfg_t                cfg_o
);

  pfl_pkg::pfl_cfg_t cfg_q, cfg_d;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[pfl_pkg::APB_AW-1:3];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        pfl_pkg::REG_SMALL_START: cfg_d.small_start = pwdata[pfl_pkg::ADDR_W-1:0];
        pfl_pkg::REG_SUPER_BASE:  cfg_d.super_base  = pwdata[pfl_pkg::ADDR_W-1:0];
        pfl_pkg::REG_PHYS_TOP:    cfg_d.phys_top    = pwdata[pfl_pkg::ADDR_W-1:0];
        default:                  cfg_d             = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pfl_pkg::REG_SMALL_START: prdata = pfl_pkg::APB_DW'(cfg_q.small_start);
      pfl_pkg::REG_SUPER_BASE:  prdata = pfl_pkg::APB_DW'(cfg_q.super_base);
      pfl_pkg::REG_PHYS_TOP:    prdata = pfl_pkg::APB_DW'(cfg_q.phys_top);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.small_start <= pfl_pkg::ADDR_W'(64'h0_8000_0000);
      cfg_q.super_base  <= pfl_pkg::ADDR_W'(64'h0_8600_0000);
      cfg_q.phys_top    <= pfl_pkg::ADDR_W'(64'h0_8800_0000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pfl_out_buf.sv =====
// Output register plus one skid entry for the result channel.
// Depends on pfl_pkg for the result type and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "two_pool_page_free_list_allocator_unit_assert.svh"

module pfl_out_buf (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          res_valid_i,
  input  wire pfl_pkg::pfl_result_t          res_i,
  output logic                               room_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [pfl_pkg::ADDR_W-1:0]    page_address_o,
  output logic      [1:0]                    status_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  pfl_pkg::pfl_result_t out_q, out_d;
  pfl_pkg::pfl_result_t skid_q, skid_d;

  assign room_o         = !skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign page_address_o = out_q.page_address;
  assign status_o       = out_q.status;

  // A new result only arrives while the skid entry is empty.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (res_valid_i) begin
      if (!out_valid_q || out_ready_i) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `PFL_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q)
  `PFL_ASSERT(a_no_res_into_full_skid, !(res_valid_i && skid_valid_q))
  `PFL_ASSERT_IMP(a_skid_fills_on_stall, $rose(skid_valid_q),
                  $past(out_valid_q && !out_ready_i))

endmodule

`default_nettype wire

// ===== sv/pfl_ctrl.sv =====
// Sequencer of the allocator: top counters, stack accesses and the init walk.
// Depends on pfl_pkg and the assertion header; drives both stack RAMs.
`timescale 1ns / 1ps
`default_nettype none
`include "two_pool_page_free_list_allocator_unit_assert.svh"

module pfl_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pfl_pkg::pfl_cfg_t                 cfg_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [2:0]                        mode_i,
  input  wire logic [pfl_pkg::ADDR_W-1:0]        address_i,
  input  wire logic                              res_room_i,
  output logic                                   res_valid_o,
  output pfl_pkg::pfl_result_t                   res_o,
  output pfl_pkg::pfl_small_req_t                small_req_o,
  input  wire logic [pfl_pkg::SMALL_PN_W-1:0]    small_rdata_i,
  output pfl_pkg::pfl_super_req_t                super_req_o,
  input  wire logic [pfl_pkg::SUPER_PN_W-1:0]    super_rdata_i
);

  localparam int STW = pfl_pkg::SMALL_TOP_W;
  localparam int UTW = pfl_pkg::SUPER_TOP_W;
  localparam int SPW = pfl_pkg::SMALL_PN_W + 1;
  localparam int UPW = pfl_pkg::SUPER_PN_W + 1;
  localparam int AW  = pfl_pkg::ADDR_W;
  localparam int SS  = pfl_pkg::SMALL_SHIFT;
  localparam int US  = pfl_pkg::SUPER_SHIFT;

  pfl_pkg::pfl_state_e state_q, state_d;
  logic [STW-1:0]      small_top_q, small_top_d, small_top_dec;
  logic [UTW-1:0]      super_top_q, super_top_d, super_top_dec;
  logic [SPW-1:0]      small_pn_q, small_pn_d, small_first, small_lim;
  logic [UPW-1:0]      super_pn_q, super_pn_d, super_first, super_lim;
  logic                sel_super_q, sel_super_d;
  logic                in_fire;
  logic                small_go, super_go;
  logic                small_free_ok, super_free_ok;

  assign in_ready_o = (state_q == pfl_pkg::S_IDLE) && res_room_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign small_top_dec = small_top_q - STW'(1);
  assign super_top_dec = super_top_q - UTW'(1);

  // First page of each pool is its lower bound rounded up to the page size.
  assign small_first = SPW'(cfg_i.small_start[AW-1:SS]) + SPW'(|cfg_i.small_start[SS-1:0]);
  assign super_first = UPW'(cfg_i.super_base[AW-1:US]) + UPW'(|cfg_i.super_base[US-1:0]);
  assign small_lim   = SPW'(cfg_i.super_base[AW-1:SS]);
  assign super_lim   = UPW'(cfg_i.phys_top[AW-1:US]);

  assign small_go = (small_top_q < STW'(pfl_pkg::SMALL_PAGES)) && (small_pn_q < small_lim);
  assign super_go = (super_top_q < UTW'(pfl_pkg::SUPER_PAGES)) && (super_pn_q < super_lim);

  assign small_free_ok = (address_i[SS-1:0] == '0) && (address_i >= cfg_i.small_start) &&
                         (address_i < cfg_i.super_base) &&
                         (small_top_q < STW'(pfl_pkg::SMALL_PAGES));
  assign super_free_ok = (address_i[US-1:0] == '0) && (address_i >= cfg_i.super_base) &&
                         (address_i < cfg_i.phys_top) &&
                         (super_top_q < UTW'(pfl_pkg::SUPER_PAGES));

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfl_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((mode_i == pfl_pkg::MODE_ALLOC_SMALL && small_top_q != '0) ||
              (mode_i == pfl_pkg::MODE_ALLOC_SUPER && super_top_q != '0)) begin
            state_d = pfl_pkg::S_READ;
          end else if (mode_i == pfl_pkg::MODE_INIT) begin
            state_d = pfl_pkg::S_INIT;
          end
        end
      end
      pfl_pkg::S_READ: state_d = pfl_pkg::S_IDLE;
      pfl_pkg::S_INIT: begin
        if (!small_go && !super_go) begin
          state_d = pfl_pkg::S_IDLE;
        end
      end
      default: state_d = pfl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_o  = 1'b0;
    res_o        = '0;
    small_req_o  = '0;
    super_req_o  = '0;
    small_top_d  = small_top_q;
    super_top_d  = super_top_q;
    small_pn_d   = small_pn_q;
    super_pn_d   = super_pn_q;
    sel_super_d  = sel_super_q;
    res_o.status = pfl_pkg::ST_OK;
    case (state_q)
      pfl_pkg::S_IDLE: begin
        if (in_fire) begin
          case (mode_i)
            pfl_pkg::MODE_ALLOC_SMALL: begin
              sel_super_d = 1'b0;
              if (small_top_q != '0) begin
                small_top_d      = small_top_dec;
                small_req_o.addr = small_top_dec[pfl_pkg::SMALL_AW-1:0];
              end else begin
                res_valid_o  = 1'b1;
                res_o.status = pfl_pkg::ST_EMPTY;
              end
            end
            pfl_pkg::MODE_ALLOC_SUPER: begin
              sel_super_d = 1'b1;
              if (super_top_q != '0) begin
                super_top_d      = super_top_dec;
                super_req_o.addr = super_top_dec[pfl_pkg::SUPER_AW-1:0];
              end else begin
                res_valid_o  = 1'b1;
                res_o.status = pfl_pkg::ST_EMPTY;
              end
            end
            pfl_pkg::MODE_FREE_SMALL: begin
              res_valid_o = 1'b1;
              if (small_free_ok) begin
                small_req_o.we    = 1'b1;
                small_req_o.addr  = small_top_q[pfl_pkg::SMALL_AW-1:0];
                small_req_o.wdata = address_i[AW-1:SS];
                small_top_d       = small_top_q + STW'(1);
              end else begin
                res_o.status = pfl_pkg::ST_BAD;
              end
            end
            pfl_pkg::MODE_FREE_SUPER: begin
              res_valid_o = 1'b1;
              if (super_free_ok) begin
                super_req_o.we    = 1'b1;
                super_req_o.addr  = super_top_q[pfl_pkg::SUPER_AW-1:0];
                super_req_o.wdata = address_i[AW-1:US];
                super_top_d       = super_top_q + UTW'(1);
              end else begin
                res_o.status = pfl_pkg::ST_BAD;
              end
            end
            pfl_pkg::MODE_INIT: begin
              small_top_d = '0;
              super_top_d = '0;
              small_pn_d  = small_first;
              super_pn_d  = super_first;
            end
            default: res_valid_o = 1'b1;
          endcase
        end
      end
      pfl_pkg::S_READ: begin
        res_valid_o = 1'b1;
        if (sel_super_q) begin
          res_o.page_address = {super_rdata_i, {US{1'b0}}};
        end else begin
          res_o.page_address = {small_rdata_i, {SS{1'b0}}};
        end
      end
      pfl_pkg::S_INIT: begin
        // Both pools fill side by side, one page of each per cycle.
        if (small_go) begin
          small_req_o.we    = 1'b1;
          small_req_o.addr  = small_top_q[pfl_pkg::SMALL_AW-1:0];
          small_req_o.wdata = small_pn_q[pfl_pkg::SMALL_PN_W-1:0];
          small_top_d       = small_top_q + STW'(1);
          small_pn_d        = small_pn_q + SPW'(1);
        end
        if (super_go) begin
          super_req_o.we    = 1'b1;
          super_req_o.addr  = super_top_q[pfl_pkg::SUPER_AW-1:0];
          super_req_o.wdata = super_pn_q[pfl_pkg::SUPER_PN_W-1:0];
          super_top_d       = super_top_q + UTW'(1);
          super_pn_d        = super_pn_q + UPW'(1);
        end
        if (!small_go && !super_go) begin
          res_valid_o = 1'b1;
        end
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfl_pkg::S_IDLE;
      small_top_q <= '0;
      super_top_q <= '0;
    end else begin
      state_q     <= state_d;
      small_top_q <= small_top_d;
      super_top_q <= super_top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    small_pn_q  <= small_pn_d;
    super_pn_q  <= super_pn_d;
    sel_super_q <= sel_super_d;
  end

  `PFL_ASSERT(a_small_top_range, small_top_q <= STW'(pfl_pkg::SMALL_PAGES))
  `PFL_ASSERT(a_super_top_range, super_top_q <= UTW'(pfl_pkg::SUPER_PAGES))
  `PFL_ASSERT_IMP(a_read_gives_result, state_q == pfl_pkg::S_READ, res_valid_o)
  `PFL_ASSERT_IMP(a_result_has_room, res_valid_o, res_room_i)

endmodule

`default_nettype wire

// ===== sv/two_pool_page_free_list_allocator_unit.sv =====
// Usage: two LIFO free lists of physical pages, 4 KiB pages and 2 MiB superpages.
// Commands enter as beats on the input channel (in_valid_i / in_ready_o) with
// mode_i and address_i; every command yields exactly one result beat on the output
// channel (out_valid_o / out_ready_i) with page_address_o and status_o.
// Frees, empty allocs and unused modes finish in the cycle of acceptance; their
// result is registered into the output buffer. An alloc that pops reads a stack
// RAM in the cycle of acceptance and its result leaves the read state into the
// output buffer. One command is in work at a time, as in_ready_o is only high in
// the idle state. Init walks both pools in parallel, one page of each per cycle,
// and gives its one result once neither pool can take another page.
// The output side has an output register and a skid entry, so a new command is
// taken while one result waits; when both are full in_ready_o stays low.
// Reset empties both stacks (top counters to zero) and loads the configuration
// registers with their defaults; no clearing pass is needed.
// Depends on pfl_pkg, pfl_cfg_regs, pfl_ctrl, pfl_ram and pfl_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module two_pool_page_free_list_allocator_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfl_pkg::APB_AW-1:0]    paddr,
  input  wire logic [pfl_pkg::APB_DW-1:0]    pwdata,
  output logic      [pfl_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [2:0]                    mode_i,
  input  wire logic [pfl_pkg::ADDR_W-1:0]    address_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [pfl_pkg::ADDR_W-1:0]    page_address_o,
  output logic      [1:0]                    status_o
);

  pfl_pkg::pfl_cfg_t              cfg;
  pfl_pkg::pfl_result_t           res;
  pfl_pkg::pfl_small_req_t        small_req;
  pfl_pkg::pfl_super_req_t        super_req;
  logic                           res_valid;
  logic                           res_room;
  logic [pfl_pkg::SMALL_PN_W-1:0] small_rdata;
  logic [pfl_pkg::SUPER_PN_W-1:0] super_rdata;

  // Address map: small_start at 0x00, super_base at 0x08, phys_top at 0x10.
  pfl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The sequencer owns the top counters and issues every stack access; it only
  // takes a command when the result path has room for it.
  pfl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .res_room_i    (res_room),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .small_req_o   (small_req),
    .small_rdata_i (small_rdata),
    .super_req_o   (super_req),
    .super_rdata_i (super_rdata)
  );

  // Small page stack: one 28-bit page number per entry.
  pfl_ram #(
    .WIDTH (pfl_pkg::SMALL_PN_W),
    .DEPTH (pfl_pkg::SMALL_PAGES)
  ) u_small_stack (
    .clk_i   (clk_i),
    .we_i    (small_req.we),
    .addr_i  (small_req.addr),
    .wdata_i (small_req.wdata),
    .rdata_o (small_rdata)
  );

  // Superpage stack: one 19-bit superpage number per entry.
  pfl_ram #(
    .WIDTH (pfl_pkg::SUPER_PN_W),
    .DEPTH (pfl_pkg::SUPER_PAGES)
  ) u_super_stack (
    .clk_i   (clk_i),
    .we_i    (super_req.we),
    .addr_i  (super_req.addr),
    .wdata_i (super_req.wdata),
    .rdata_o (super_rdata)
  );

  // Output register with a skid entry decouples the result receiver.
  pfl_out_buf u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_i          (res),
    .room_o         (res_room),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .page_address_o (page_address_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

// ===== tb/two_pool_page_free_list_allocator_unit_tb.sv =====
// Self-checking bench for the two-pool page free list allocator (small pages and superpages).
// Holds a scoreboard class with its own model of both LIFO pools and plain driver tasks.
// Depends on pfl_pkg and the two_pool_page_free_list_allocator_unit top level.
`timescale 1ns / 1ps

module two_pool_page_free_list_allocator_unit_tb;
  import pfl_pkg::*;

  // Mode codes 5 to 7 carry no operation; the block must answer them with a plain ok beat.
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  localparam logic [63:0] ADDR_MASK   = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] SMALL_BYTES = 64'd1 << SMALL_SHIFT;
  localparam logic [63:0] SUPER_BYTES = 64'd1 << SUPER_SHIFT;

  // An init over a full small pool moves no beat until it ends, so the watchdog allows
  // several times the length of that walk before it calls the run hung.
  localparam int STALL_LIMIT = 150000;

  // Register layouts the random phases run under.
  typedef enum int {
    LAYOUT_SCATTER,
    LAYOUT_ZERO,
    LAYOUT_ONES,
    LAYOUT_INVERTED,
    LAYOUT_LOW_EDGE,
    LAYOUT_HIGH_EDGE
  } layout_e;

  // Keeps a private copy of both page stacks and the three bound registers, works out the
  // result beat of every accepted command, and compares result beats in order.
  class page_pool_scoreboard;
    logic [SMALL_PN_W-1:0] small_pages [SMALL_PAGES];
    logic [SUPER_PN_W-1:0] super_pages [SUPER_PAGES];
    int unsigned           small_count;
    int unsigned           super_count;
    logic [63:0]           small_start;
    logic [63:0]           super_base;
    logic [63:0]           phys_top;
    pfl_result_t           pending[$];
    int unsigned           mode_hits [8];
    int unsigned           results_seen;
    int unsigned           mismatches;

    function new();
      small_start = 64'h8000_0000;
      super_base  = 64'h8600_0000;
      phys_top    = 64'h8800_0000;
      small_count = 0;
      super_count = 0;
      results_seen = 0;
      mismatches = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    static function logic [63:0] round_to_boundary(logic [63:0] x, int shift);
      logic [63:0] m;
      m = (64'd1 << shift) - 64'd1;
      return (x + m) & ~m;
    endfunction

    function void write_reg(pfl_reg_e idx, logic [63:0] value);
      case (idx)
        REG_SMALL_START: small_start = value & ADDR_MASK;
        REG_SUPER_BASE:  super_base = value & ADDR_MASK;
        REG_PHYS_TOP:    phys_top = value & ADDR_MASK;
        default: ;
      endcase
    endfunction

    function void note_command(logic [2:0] mode, logic [ADDR_W-1:0] addr);
      pfl_result_t res;
      logic [63:0] a;
      logic [63:0] p;
      res.page_address = '0;
      res.status = ST_OK;
      a = 64'(addr);
      mode_hits[mode]++;
      case (mode)
        MODE_ALLOC_SMALL: begin
          if (small_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            small_count--;
            res.page_address = ADDR_W'(64'(small_pages[small_count]) << SMALL_SHIFT);
          end
        end
        MODE_FREE_SMALL: begin
          if ((a & (SMALL_BYTES - 1)) != 0 || a < small_start || a >= super_base ||
              small_count >= SMALL_PAGES) begin
            res.status = ST_BAD;
          end else begin
            small_pages[small_count] = SMALL_PN_W'(a >> SMALL_SHIFT);
            small_count++;
          end
        end
        MODE_ALLOC_SUPER: begin
          if (super_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            super_count--;
            res.page_address = ADDR_W'(64'(super_pages[super_count]) << SUPER_SHIFT);
          end
        end
        MODE_FREE_SUPER: begin
          if ((a & (SUPER_BYTES - 1)) != 0 || a < super_base || a >= phys_top ||
              super_count >= SUPER_PAGES) begin
            res.status = ST_BAD;
          end else begin
            super_pages[super_count] = SUPER_PN_W'(a >> SUPER_SHIFT);
            super_count++;
          end
        end
        MODE_INIT: begin
          // Both pools restart empty and refill in ascending order until the range or
          // the stack runs out, whichever comes first.
          small_count = 0;
          super_count = 0;
          p = round_to_boundary(small_start, SMALL_SHIFT);
          while (small_count < SMALL_PAGES && p + SMALL_BYTES <= super_base) begin
            small_pages[small_count] = SMALL_PN_W'(p >> SMALL_SHIFT);
            small_count++;
            p += SMALL_BYTES;
          end
          p = round_to_boundary(super_base, SUPER_SHIFT);
          while (super_count < SUPER_PAGES && p + SUPER_BYTES <= phys_top) begin
            super_pages[super_count] = SUPER_PN_W'(p >> SUPER_SHIFT);
            super_count++;
            p += SUPER_BYTES;
          end
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(logic [ADDR_W-1:0] page, logic [1:0] status);
      pfl_result_t want;
      bit          orphan;
      results_seen++;
      want = '0;
      orphan = (pending.size() == 0);
      if (!orphan) want = pending.pop_front();
      if (orphan || page !== want.page_address || status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%s expected page %h status %0d, got page %h status %0d",
                   orphan ? "result beat with nothing pending:" : "result mismatch:",
                   want.page_address, want.status, page, status);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [2:0]          mode_i      = '0;
  logic [ADDR_W-1:0]   address_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ADDR_W-1:0]   page_address_o;
  logic [1:0]          status_o;

  page_pool_scoreboard sb;

  // Bounds as last written, kept on the stimulus side to aim frees at the pools.
  logic [63:0] cfg_small_start = 64'h8000_0000;
  logic [63:0] cfg_super_base  = 64'h8600_0000;
  logic [63:0] cfg_phys_top    = 64'h8800_0000;

  int  stall_cycles  = 0;
  int  layouts_used  = 0;
  // While set, neither side of the data path idles.
  bit  calm_stretch  = 1'b0;

  two_pool_page_free_list_allocator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .page_address_o (page_address_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver drops ready in about a quarter of the cycles, except in the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm_stretch || ($urandom_range(0, 99) >= 24);
  end

  // Monitor: every signal is read at the clock edge, before any update of that edge lands,
  // so a beat counts exactly when valid and ready were both high going into the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_command(mode_i, address_i);
      if (out_valid_o && out_ready_i) sb.check_result(page_address_o, status_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // Drives one command beat. Random idle cycles may come first; valid then stays high with
  // the payload fixed until the beat is taken. Every call starts and ends on a clock edge.
  task automatic send_command(logic [2:0] mode, logic [ADDR_W-1:0] addr);
    while (!calm_stretch && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    address_i  <= addr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Lowers valid and waits for every outstanding result beat. The first edge lets the
  // monitor note a beat taken at the edge this task was called on.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // One APB write: a setup phase, then an access phase held until pready is seen.
  task automatic write_register(pfl_reg_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Writes all three bounds. Junk in the upper bits checks that writes keep only 40 bits.
  task automatic configure(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
    write_register(REG_SMALL_START, {24'($urandom), lo[ADDR_W-1:0]});
    write_register(REG_SUPER_BASE, {24'($urandom), mid[ADDR_W-1:0]});
    write_register(REG_PHYS_TOP, {24'($urandom), hi[ADDR_W-1:0]});
    cfg_small_start = lo & ADDR_MASK;
    cfg_super_base  = mid & ADDR_MASK;
    cfg_phys_top    = hi & ADDR_MASK;
    layouts_used++;
  endtask

  // Mostly an aligned page inside the pool, else a misaligned one, one just outside either
  // bound, or a fully random address.
  function automatic logic [ADDR_W-1:0] pick_free_address(bit big_page);
    int          shift;
    logic [63:0] step;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] first;
    logic [63:0] span;
    logic [63:0] pick;
    int unsigned roll;
    shift = big_page ? SUPER_SHIFT : SMALL_SHIFT;
    step  = 64'd1 << shift;
    lo    = big_page ? cfg_super_base : cfg_small_start;
    hi    = big_page ? cfg_phys_top : cfg_super_base;
    first = page_pool_scoreboard::round_to_boundary(lo, shift);
    span  = (hi > first) ? (hi - first) >> shift : 64'd0;
    if (span > 64'd4096) span = 64'd4096;
    if (span == 0) span = 64'd1;
    pick = first + 64'($urandom_range(0, 32'(span) - 1)) * step;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      pick = pick + 64'($urandom_range(1, 32'(step) - 1));
    end else if (roll < 15) begin
      pick = page_pool_scoreboard::round_to_boundary(hi, shift) +
             64'($urandom_range(0, 2)) * step;
    end else if (roll < 20) begin
      pick = (lo & ~(step - 1)) - 64'($urandom_range(1, 3)) * step;
    end else if (roll < 28) begin
      pick = {$urandom, $urandom};
    end
    return pick[ADDR_W-1:0];
  endfunction

  // One random phase: pick bounds for the layout, write them while idle, start with an init
  // that refills the pools, then mix allocs and frees with a few inits and spare modes.
  task automatic run_layout(layout_e layout, int beats);
    logic [63:0] lo;
    logic [63:0] mid;
    logic [63:0] hi;
    logic [63:0] base;
    logic [2:0]  mode;
    logic [ADDR_W-1:0] addr;
    int unsigned roll;
    base = ((64'($urandom_range(0, 254)) << 32) | 64'($urandom)) & ~(SMALL_BYTES - 1);
    case (layout)
      LAYOUT_SCATTER: begin
        lo  = base + (($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 4095)) : 64'd0);
        mid = lo + 64'($urandom_range(0, 64)) * SMALL_BYTES +
              (($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 4095)) : 64'd0);
        hi  = page_pool_scoreboard::round_to_boundary(mid, SUPER_SHIFT) +
              64'($urandom_range(0, 80)) * SUPER_BYTES +
              (($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 4095)) : 64'd0);
      end
      LAYOUT_ZERO: begin
        lo  = 64'd0;
        mid = 64'd0;
        hi  = 64'd0;
      end
      LAYOUT_ONES: begin
        // Rounding the superpage base up runs past the 40-bit space, so nothing fits.
        lo  = ADDR_MASK;
        mid = ADDR_MASK;
        hi  = ADDR_MASK;
      end
      LAYOUT_INVERTED: begin
        // Both ranges are empty or run backwards; every free is refused and init pushes nothing.
        mid = base + 64'h40_0000;
        lo  = mid + 64'($urandom_range(1, 64)) * SMALL_BYTES;
        hi  = mid - 64'($urandom_range(0, 32'(SUPER_BYTES)));
      end
      LAYOUT_LOW_EDGE: begin
        // The small pool starts at address zero.
        lo  = 64'd0;
        mid = 64'($urandom_range(1, 48)) * SMALL_BYTES +
              (($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 4095)) : 64'd0);
        hi  = page_pool_scoreboard::round_to_boundary(mid, SUPER_SHIFT) +
              64'($urandom_range(0, 72)) * SUPER_BYTES;
      end
      default: begin
        // The superpool ends at the last byte, so init never pushes its topmost superpage.
        hi  = ADDR_MASK;
        mid = hi - 64'($urandom_range(1, 6)) * SUPER_BYTES - 64'($urandom_range(0, 4095));
        lo  = mid - 64'($urandom_range(0, 48)) * SMALL_BYTES -
              64'($urandom_range(0, 4095));
      end
    endcase
    configure(lo, mid, hi);
    send_command(MODE_INIT, {$urandom, $urandom});
    repeat (beats - 1) begin
      roll = $urandom_range(0, 99);
      if (roll < 28) mode = MODE_ALLOC_SMALL;
      else if (roll < 52) mode = MODE_FREE_SMALL;
      else if (roll < 66) mode = MODE_ALLOC_SUPER;
      else if (roll < 88) mode = MODE_FREE_SUPER;
      else if (roll < 93) mode = MODE_INIT;
      else mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      if (mode == MODE_FREE_SMALL) addr = pick_free_address(1'b0);
      else if (mode == MODE_FREE_SUPER) addr = pick_free_address(1'b1);
      else addr = {$urandom, $urandom};
      send_command(mode, addr);
    end
    drain_results();
  endtask

  initial begin
    int unsigned failures;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset bounds: both pools start empty, so allocs report empty until something lands.
    send_command(MODE_ALLOC_SMALL, '1);
    send_command(MODE_ALLOC_SUPER, '0);
    // Small frees at both ends of the pool, then misaligned, below the start and at the
    // superpage boundary.
    send_command(MODE_FREE_SMALL, 40'h00_8000_0000);
    send_command(MODE_FREE_SMALL, 40'h00_85FF_F000);
    send_command(MODE_FREE_SMALL, 40'h00_8000_0800);
    send_command(MODE_FREE_SMALL, 40'h00_7FFF_F000);
    send_command(MODE_FREE_SMALL, 40'h00_8600_0000);
    // Superpage frees: first and last page, at the top, misaligned and below the base.
    send_command(MODE_FREE_SUPER, 40'h00_8600_0000);
    send_command(MODE_FREE_SUPER, 40'h00_87E0_0000);
    send_command(MODE_FREE_SUPER, 40'h00_8800_0000);
    send_command(MODE_FREE_SUPER, 40'h00_8610_0000);
    send_command(MODE_FREE_SUPER, 40'h00_8400_0000);
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) send_command(3'(m), '1);
    // The pops come back in reverse order of the pushes.
    send_command(MODE_ALLOC_SMALL, '0);
    send_command(MODE_ALLOC_SUPER, '1);
    // An init over the whole reset layout, then one pop from each pool.
    send_command(MODE_INIT, '1);
    send_command(MODE_ALLOC_SMALL, '0);
    send_command(MODE_ALLOC_SUPER, '0);
    drain_results();

    // Both ranges hold more pages than the stacks: init stops at capacity and frees into a
    // full stack are refused until a pop makes room.
    configure(64'd0, 64'h1000_0000, 64'h1C80_0000);
    send_command(MODE_INIT, '0);
    send_command(MODE_FREE_SMALL, 40'h00_0000_0000);
    send_command(MODE_FREE_SUPER, 40'h00_1000_0000);
    send_command(MODE_ALLOC_SMALL, '1);
    send_command(MODE_ALLOC_SUPER, '1);
    send_command(MODE_FREE_SMALL, 40'h00_07FF_F000);
    drain_results();

    run_layout(LAYOUT_SCATTER, 330);
    run_layout(LAYOUT_ZERO, 60);
    run_layout(LAYOUT_LOW_EDGE, 250);
    run_layout(LAYOUT_INVERTED, 80);
    run_layout(LAYOUT_HIGH_EDGE, 250);
    calm_stretch = 1'b1;
    run_layout(LAYOUT_SCATTER, 330);
    calm_stretch = 1'b0;
    run_layout(LAYOUT_ONES, 60);
    run_layout(LAYOUT_SCATTER, 330);

    // Leave room for any stray result beat to show up before the final count.
    repeat (20) @(posedge clk_i);
    failures = sb.mismatches + sb.pending.size();
    $display("ran %0d allocs, %0d frees, %0d inits and %0d spare-mode beats",
             sb.mode_hits[MODE_ALLOC_SMALL] + sb.mode_hits[MODE_ALLOC_SUPER],
             sb.mode_hits[MODE_FREE_SMALL] + sb.mode_hits[MODE_FREE_SUPER],
             sb.mode_hits[MODE_INIT],
             sb.mode_hits[5] + sb.mode_hits[6] + sb.mode_hits[7]);
    $display("checked %0d result beats over %0d register layouts, %0d failures",
             sb.results_seen, layouts_used + 1, failures);
    if (failures == 0) begin
      $display("two_pool_page_free_list_allocator_unit_tb: done, clean");
    end else begin
      $display("two_pool_page_free_list_allocator_unit_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: ends the run when no beat has moved on either channel for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
    $display("two_pool_page_free_list_allocator_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pfl_pkg.sv
sv/pfl_ram.sv
sv/pfl_cfg_regs.sv
sv/pfl_out_buf.sv
sv/pfl_ctrl.sv
sv/two_pool_page_free_list_allocator_unit.sv
tb/two_pool_page_free_list_allocator_unit_tb.sv
